[rtl/mlfts_pkg.sv]
`default_nettype none

package mlfts_pkg;

  localparam int unsigned QUANTUM_W = 20;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd2;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_SCHED  = 2'd1;
  localparam logic [1:0] KIND_WAKE   = 2'd2;

  localparam logic [1:0] DISP_EXIT = 2'd1;
  localparam logic [1:0] DISP_WAIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd2;

  localparam logic [QUANTUM_W-1:0] QUANTUM0_RESET = 20'd25000;
  localparam logic [QUANTUM_W-1:0] QUANTUM1_RESET = 20'd50000;
  localparam logic [QUANTUM_W-1:0] QUANTUM2_RESET = 20'd100000;

  localparam logic [RUN_W-1:0] RUN_ADD_L0   = 8'd15;
  localparam logic [RUN_W-1:0] RUN_ADD_L1   = 8'd30;
  localparam logic [RUN_W-1:0] RUN_ADD_HI   = 8'd60;
  localparam logic [RUN_W-1:0] RUN_BOOST_AT = 8'd225;
  localparam logic [RUN_W-1:0] RUN_MAX      = 8'd255;

endpackage

`default_nettype wire

[rtl/multilevel_feedback_thread_scheduler.sv]
`default_nettype none

// Multilevel feedback thread scheduler. One item is handled at a time by a
// small sequencer around two single-port synchronous memories: the thread
// table (status, level, run time per thread) and the ready queue store (one
// FIFO region per level). A schedule or create skips the accounting when no
// thread is running and the queue read when no thread is dispatched. The
// steps are set by the read-modify-write of the thread table followed by
// the queue read for the dispatch. A result waiting on rsp_stall holds the
// sequencer in its last step. Thread ids are handed out in order and never
// reused, so the thread table needs no clearing: entries above the thread
// count read as free, and the main thread (id 1) reads as ready at level 0
// until first written. Quanta are to be written through the cfg port only
// while idle; the block itself does not enforce this.
module multilevel_feedback_thread_scheduler #(
  parameter int unsigned LEVELS      = 3,
  parameter int unsigned MAX_THREADS = 64,
  localparam int unsigned TID_W      = $clog2(MAX_THREADS),
  localparam int unsigned LVL_W      = $clog2(LEVELS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mlfts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mlfts_pkg::QUANTUM_W-1:0]     cfg_data,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [1:0]                          kind,
  input  wire logic [3:0]                          priority_req,
  input  wire logic [1:0]                          disposition,
  input  wire logic [TID_W-1:0]                    wake_tid,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic [TID_W-1:0]                         created_tid,
  output logic                                     table_full,
  output logic                                     dispatched,
  output logic [TID_W-1:0]                         next_tid,
  output logic [LVL_W-1:0]                         next_level,
  output logic [mlfts_pkg::QUANTUM_W-1:0]          quantum_us
);

  localparam int unsigned QDEPTH = LEVELS * MAX_THREADS;
  localparam int unsigned QA_W   = $clog2(QDEPTH);
  localparam int unsigned FILL_W = $clog2(MAX_THREADS + 1);
  localparam int unsigned TE_W   = mlfts_pkg::STATUS_W + LVL_W + mlfts_pkg::RUN_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CREATE = 9'b000000010,
    S_READ   = 9'b000000100,
    S_ACCT   = 9'b000001000,
    S_PICK   = 9'b000010000,
    S_DISP   = 9'b000100000,
    S_WREAD  = 9'b001000000,
    S_WCHK   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [mlfts_pkg::QUANTUM_W-1:0] quantum0, quantum1, quantum2;

  logic [TID_W-1:0]  running_tid, running_tid_next;
  logic              running_valid, running_valid_next;
  logic [TID_W-1:0]  thread_count, thread_count_next;
  logic              main_written, main_written_next;
  logic [TID_W-1:0]  queue_head [LEVELS];
  logic [TID_W-1:0]  queue_tail [LEVELS];
  logic [FILL_W-1:0] queue_fill [LEVELS];

  // latched item fields
  logic [3:0]       prio_r;
  logic [1:0]       disp_r;
  logic [TID_W-1:0] wake_r;

  // result being built
  logic [TID_W-1:0]                res_created, res_created_next;
  logic                            res_full, res_full_next;
  logic                            res_disp, res_disp_next;
  logic [TID_W-1:0]                res_tid, res_tid_next;
  logic [LVL_W-1:0]                res_level, res_level_next;
  logic [mlfts_pkg::QUANTUM_W-1:0] res_quant, res_quant_next;

  // memories
  logic [TE_W-1:0]  thread_mem [MAX_THREADS];
  logic [TID_W-1:0] queue_mem  [QDEPTH];

  logic             tm_re, tm_we;
  logic [TID_W-1:0] tm_raddr, tm_waddr;
  logic [TE_W-1:0]  tm_wdata, tm_rdata;
  logic             tm_ok, tm_main;

  logic             qm_re;
  logic [QA_W-1:0]  qm_raddr;
  logic [TID_W-1:0] qm_rdata;

  logic             enq_en;
  logic [LVL_W-1:0] enq_lv;
  logic [TID_W-1:0] enq_tid;
  logic             deq_en;
  logic [LVL_W-1:0] deq_lv;

  logic req_accept, rsp_load;

  // decoded thread table read
  logic [mlfts_pkg::STATUS_W-1:0] rd_status;
  logic [LVL_W-1:0]               rd_level;
  logic [mlfts_pkg::RUN_W-1:0]    rd_run;

  // accounting
  logic [mlfts_pkg::RUN_W-1:0] run_add;
  logic [mlfts_pkg::RUN_W:0]   run_sum;
  logic [mlfts_pkg::RUN_W-1:0] run_new;
  logic [LVL_W-1:0]            lv_acct, lv_demoted;

  logic [TID_W-1:0] wake_mod;
  logic [TID_W-1:0] new_tid;
  logic [LVL_W-1:0] prio_lv;
  logic             pick_found;
  logic [LVL_W-1:0] pick_lv;

  assign cfg_ready  = 1'b1;
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;

  assign wake_mod = ({1'b0, wake_r} >= (TID_W + 1)'(MAX_THREADS)) ?
                    TID_W'({1'b0, wake_r} - (TID_W + 1)'(MAX_THREADS)) : wake_r;
  assign new_tid  = thread_count + TID_W'(1);
  assign prio_lv  = (prio_r > 4'(LEVELS - 1)) ? LVL_W'(LEVELS - 1) : prio_r[LVL_W-1:0];

  always_comb begin
    if (tm_ok) begin
      {rd_status, rd_level, rd_run} = tm_rdata;
    end else begin
      rd_status = tm_main ? mlfts_pkg::ST_READY : mlfts_pkg::ST_FREE;
      rd_level  = '0;
      rd_run    = '0;
    end
  end

  always_comb begin
    if (rd_level == LVL_W'(0)) begin
      run_add = mlfts_pkg::RUN_ADD_L0;
    end else if (rd_level == LVL_W'(1)) begin
      run_add = mlfts_pkg::RUN_ADD_L1;
    end else begin
      run_add = mlfts_pkg::RUN_ADD_HI;
    end
    run_sum = {1'b0, rd_run} + {1'b0, run_add};
    run_new = run_sum[mlfts_pkg::RUN_W] ? mlfts_pkg::RUN_MAX : run_sum[mlfts_pkg::RUN_W-1:0];
    lv_acct = rd_level;
    // long-running bottom-level thread goes back to the top
    if (({1'b0, rd_level} >= (LVL_W + 1)'(2)) && (run_new >= mlfts_pkg::RUN_BOOST_AT)) begin
      lv_acct = '0;
      run_new = '0;
    end
    lv_demoted = (lv_acct < LVL_W'(LEVELS - 1)) ? lv_acct + LVL_W'(1) : lv_acct;
  end

  always_comb begin
    pick_found = 1'b0;
    pick_lv    = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (queue_fill[l] != '0) begin
        pick_found = 1'b1;
        pick_lv    = LVL_W'(l);
      end
    end
  end

  always_comb begin
    state_next         = state;
    running_tid_next   = running_tid;
    running_valid_next = running_valid;
    thread_count_next  = thread_count;
    main_written_next  = main_written;
    res_created_next   = res_created;
    res_full_next      = res_full;
    res_disp_next      = res_disp;
    res_tid_next       = res_tid;
    res_level_next     = res_level;
    res_quant_next     = res_quant;
    tm_re    = 1'b0;
    tm_raddr = running_tid;
    tm_we    = 1'b0;
    tm_waddr = running_tid;
    tm_wdata = {rd_status, rd_level, rd_run};
    enq_en   = 1'b0;
    enq_lv   = lv_demoted;
    enq_tid  = running_tid;
    deq_en   = 1'b0;
    deq_lv   = pick_lv;
    qm_re    = 1'b0;
    rsp_load = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          res_created_next = '0;
          res_full_next    = 1'b0;
          res_disp_next    = 1'b0;
          res_tid_next     = '0;
          res_level_next   = '0;
          res_quant_next   = '0;
          case (kind)
            mlfts_pkg::KIND_CREATE: state_next = S_CREATE;
            mlfts_pkg::KIND_SCHED:  state_next = S_READ;
            mlfts_pkg::KIND_WAKE:   state_next = S_WREAD;
            default:                state_next = S_FINISH;
          endcase
        end
      end
      S_CREATE: begin
        if (thread_count >= TID_W'(MAX_THREADS - 1)) begin
          res_full_next = 1'b1;
        end else begin
          thread_count_next = new_tid;
          tm_we            = 1'b1;
          tm_waddr         = new_tid;
          tm_wdata         = {mlfts_pkg::ST_READY, prio_lv, {mlfts_pkg::RUN_W{1'b0}}};
          enq_en           = 1'b1;
          enq_lv           = prio_lv;
          enq_tid          = new_tid;
          res_created_next = new_tid;
        end
        state_next = S_READ;
      end
      S_READ: begin
        if (running_valid) begin
          tm_re      = 1'b1;
          tm_raddr   = running_tid;
          state_next = S_ACCT;
        end else begin
          state_next = S_PICK;
        end
      end
      S_ACCT: begin
        tm_we    = 1'b1;
        tm_waddr = running_tid;
        if (disp_r == mlfts_pkg::DISP_EXIT) begin
          tm_wdata = {mlfts_pkg::ST_FREE, lv_acct, run_new};
        end else if (disp_r == mlfts_pkg::DISP_WAIT) begin
          tm_wdata = {mlfts_pkg::ST_WAIT, lv_acct, run_new};
        end else begin
          tm_wdata = {mlfts_pkg::ST_READY, lv_demoted, run_new};
          enq_en   = 1'b1;
          enq_lv   = lv_demoted;
          enq_tid  = running_tid;
        end
        if (running_tid == TID_W'(1)) begin
          main_written_next = 1'b1;
        end
        state_next = S_PICK;
      end
      S_PICK: begin
        if (pick_found) begin
          deq_en             = 1'b1;
          deq_lv             = pick_lv;
          qm_re              = 1'b1;
          running_valid_next = 1'b1;
          res_disp_next      = 1'b1;
          res_level_next     = pick_lv;
          if (pick_lv == LVL_W'(0)) begin
            res_quant_next = quantum0;
          end else if (pick_lv == LVL_W'(1)) begin
            res_quant_next = quantum1;
          end else begin
            res_quant_next = quantum2;
          end
          state_next = S_DISP;
        end else begin
          running_valid_next = 1'b0;
          state_next         = S_FINISH;
        end
      end
      S_DISP: begin
        running_tid_next = qm_rdata;
        res_tid_next     = qm_rdata;
        state_next       = S_FINISH;
      end
      S_WREAD: begin
        tm_re      = 1'b1;
        tm_raddr   = wake_mod;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (rd_status == mlfts_pkg::ST_WAIT) begin
          tm_we    = 1'b1;
          tm_waddr = wake_mod;
          tm_wdata = {mlfts_pkg::ST_READY, rd_level, rd_run};
          enq_en   = 1'b1;
          enq_lv   = rd_level;
          enq_tid  = wake_mod;
          if (wake_mod == TID_W'(1)) begin
            main_written_next = 1'b1;
          end
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign qm_raddr = QA_W'(deq_lv) * QA_W'(MAX_THREADS) + QA_W'(queue_head[deq_lv]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_tid   <= TID_W'(1);
      running_valid <= 1'b1;
      thread_count  <= TID_W'(1);
      main_written  <= 1'b0;
      rsp_valid     <= 1'b0;
      quantum0      <= mlfts_pkg::QUANTUM0_RESET;
      quantum1      <= mlfts_pkg::QUANTUM1_RESET;
      quantum2      <= mlfts_pkg::QUANTUM2_RESET;
      for (int l = 0; l < LEVELS; l++) begin
        queue_head[l] <= '0;
        queue_tail[l] <= '0;
        queue_fill[l] <= '0;
      end
    end else begin
      state         <= state_next;
      running_tid   <= running_tid_next;
      running_valid <= running_valid_next;
      thread_count  <= thread_count_next;
      main_written  <= main_written_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          mlfts_pkg::CFG_QUANTUM0: quantum0 <= cfg_data;
          mlfts_pkg::CFG_QUANTUM1: quantum1 <= cfg_data;
          mlfts_pkg::CFG_QUANTUM2: quantum2 <= cfg_data;
          default: ;
        endcase
      end
      // drop an enqueue into a full level
      if (enq_en && (queue_fill[enq_lv] < FILL_W'(MAX_THREADS))) begin
        queue_tail[enq_lv] <= (queue_tail[enq_lv] == TID_W'(MAX_THREADS - 1)) ?
                              '0 : queue_tail[enq_lv] + TID_W'(1);
        queue_fill[enq_lv] <= queue_fill[enq_lv] + FILL_W'(1);
      end
      if (deq_en) begin
        queue_head[deq_lv] <= (queue_head[deq_lv] == TID_W'(MAX_THREADS - 1)) ?
                              '0 : queue_head[deq_lv] + TID_W'(1);
        queue_fill[deq_lv] <= queue_fill[deq_lv] - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      prio_r <= priority_req;
      disp_r <= disposition;
      wake_r <= wake_tid;
    end
    res_created <= res_created_next;
    res_full    <= res_full_next;
    res_disp    <= res_disp_next;
    res_tid     <= res_tid_next;
    res_level   <= res_level_next;
    res_quant   <= res_quant_next;
    if (rsp_load) begin
      created_tid <= res_created;
      table_full  <= res_full;
      dispatched  <= res_disp;
      next_tid    <= res_tid;
      next_level  <= res_level;
      quantum_us  <= res_quant;
    end
  end

  // thread table
  always_ff @(posedge clk) begin
    if (tm_we) begin
      thread_mem[tm_waddr] <= tm_wdata;
    end
    if (tm_re) begin
      tm_rdata <= thread_mem[tm_raddr];
      tm_ok    <= (tm_raddr == TID_W'(1)) ? main_written :
                  ((tm_raddr >= TID_W'(2)) && (tm_raddr <= thread_count));
      tm_main  <= (tm_raddr == TID_W'(1));
    end
  end

  // ready queue store
  always_ff @(posedge clk) begin
    if (enq_en && (queue_fill[enq_lv] < FILL_W'(MAX_THREADS))) begin
      queue_mem[QA_W'(enq_lv) * QA_W'(MAX_THREADS) + QA_W'(queue_tail[enq_lv])] <= enq_tid;
    end
    if (qm_re) begin
      qm_rdata <= queue_mem[qm_raddr];
    end
  end

endmodule

`default_nettype wire

[test/tb_multilevel_feedback_thread_scheduler.sv]
`default_nettype none

module tb_multilevel_feedback_thread_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CFG_IDX_W = mlfts_pkg::CFG_IDX_W;
  localparam int unsigned QUANTUM_W = mlfts_pkg::QUANTUM_W;

  localparam logic [1:0] KIND_CREATE = mlfts_pkg::KIND_CREATE;
  localparam logic [1:0] KIND_SCHED  = mlfts_pkg::KIND_SCHED;
  localparam logic [1:0] KIND_WAKE   = mlfts_pkg::KIND_WAKE;
  localparam logic [1:0] DISP_EXIT   = mlfts_pkg::DISP_EXIT;
  localparam logic [1:0] DISP_WAIT   = mlfts_pkg::DISP_WAIT;
  localparam logic [1:0] ST_FREE     = mlfts_pkg::ST_FREE;
  localparam logic [1:0] ST_READY    = mlfts_pkg::ST_READY;
  localparam logic [1:0] ST_WAIT     = mlfts_pkg::ST_WAIT;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = mlfts_pkg::CFG_QUANTUM0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = mlfts_pkg::CFG_QUANTUM1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = mlfts_pkg::CFG_QUANTUM2;

  localparam int unsigned LEVELS      = 3;
  localparam int unsigned MAX_THREADS = 64;
  localparam int unsigned SEGMENTS    = 6;
  localparam int unsigned SEG_ITEMS   = 225;
  localparam int unsigned SETTLE_CYC  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] DISP_READY  = 2'd0;
  localparam logic [1:0] DISP_ODD    = 2'd3;

  localparam int unsigned STEP_L0  = 15;
  localparam int unsigned STEP_L1  = 30;
  localparam int unsigned STEP_HI  = 60;
  localparam int unsigned BOOST_AT = 225;
  localparam int unsigned RT_SAT   = 255;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] priority_req;
    logic [1:0] disposition;
    logic [5:0] wake_tid;
  } sched_item_t;

  typedef struct packed {
    logic [5:0]  created_tid;
    logic        table_full;
    logic        dispatched;
    logic [5:0]  next_tid;
    logic [1:0]  next_level;
    logic [19:0] quantum_us;
  } sched_result_t;

  typedef struct packed {
    sched_item_t   item;
    logic          typed;
    sched_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUANTUM_W-1:0] cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [1:0]           kind = '0;
  logic [3:0]           priority_req = '0;
  logic [1:0]           disposition = '0;
  logic [5:0]           wake_tid = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [5:0]           created_tid;
  logic                 table_full;
  logic                 dispatched;
  logic [5:0]           next_tid;
  logic [1:0]           next_level;
  logic [QUANTUM_W-1:0] quantum_us;

  multilevel_feedback_thread_scheduler u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler mirror
  logic [19:0] quantum_cfg [LEVELS];
  logic [5:0]  cur_tid = 6'd1;
  logic        cur_valid = 1'b1;
  int unsigned thread_total = 1;
  logic [1:0]  lvl_of [MAX_THREADS];
  logic [7:0]  runtime_of [MAX_THREADS];
  logic [1:0]  status_of [MAX_THREADS];
  logic [5:0]  fifo_mem [LEVELS][MAX_THREADS];
  int unsigned fifo_head [LEVELS];
  int unsigned fifo_tail [LEVELS];
  int unsigned fifo_fill [LEVELS];

  sched_result_t awaited_decisions [$];

  int unsigned req_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned refused_creates = 0;
  int unsigned idle_schedules = 0;
  int unsigned boosts = 0;
  int unsigned cycle_count = 0;

  // after reset, extremes of the fields, every kind, wait/wake/exit, empty queues
  stim_row_t directed_rows [24] = '{
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b1, '{6'd0, 1'b0, 1'b1, 6'd1, 2'd1, 20'd50000}},
    '{'{KIND_CREATE, 4'd15, DISP_READY, 6'd0},  1'b1, '{6'd2, 1'b0, 1'b1, 6'd2, 2'd2, 20'd100000}},
    '{'{KIND_CREATE, 4'd0,  DISP_ODD,   6'd0},  1'b1, '{6'd3, 1'b0, 1'b1, 6'd3, 2'd0, 20'd25000}},
    '{'{KIND_SCHED,  4'd0,  DISP_WAIT,  6'd0},  1'b1, '{6'd0, 1'b0, 1'b1, 6'd1, 2'd2, 20'd100000}},
    '{'{KIND_WAKE,   4'd0,  DISP_READY, 6'd3},  1'b1, '0},
    '{'{KIND_WAKE,   4'd0,  DISP_READY, 6'd3},  1'b1, '0},
    '{'{KIND_UNUSED, 4'd15, DISP_ODD,   6'd63}, 1'b1, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_EXIT,  6'd0},  1'b1, '{6'd0, 1'b0, 1'b1, 6'd3, 2'd0, 20'd25000}},
    '{'{KIND_WAKE,   4'd0,  DISP_READY, 6'd1},  1'b1, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_WAIT,  6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_WAIT,  6'd0},  1'b1, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b1, '0},
    '{'{KIND_WAKE,   4'd0,  DISP_READY, 6'd3},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_EXIT,  6'd0},  1'b0, '0},
    '{'{KIND_WAKE,   4'd0,  DISP_READY, 6'd2},  1'b0, '0},
    '{'{KIND_CREATE, 4'd1,  DISP_READY, 6'd42}, 1'b0, '0},
    '{'{KIND_SCHED,  4'd2,  DISP_READY, 6'd21}, 1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_ODD,   6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_ODD,   6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b0, '0},
    '{'{KIND_SCHED,  4'd0,  DISP_READY, 6'd0},  1'b0, '0}
  };

  function automatic void push_ready(logic [5:0] t);
    int unsigned l;
    l = lvl_of[t];
    if (l > LEVELS - 1) l = LEVELS - 1;
    if (fifo_fill[l] < MAX_THREADS) begin
      fifo_mem[l][fifo_tail[l]] = t;
      fifo_tail[l] = (fifo_tail[l] + 1) % MAX_THREADS;
      fifo_fill[l]++;
    end
  endfunction

  function automatic sched_result_t predict_decision(sched_item_t it);
    sched_result_t r;
    logic [1:0]    disp;
    logic [5:0]    t;
    int unsigned   lv;
    int unsigned   rt;
    r = '0;
    disp = (it.disposition == DISP_ODD) ? DISP_READY : it.disposition;
    case (it.kind)
      KIND_WAKE: begin
        if (status_of[it.wake_tid] == ST_WAIT) begin
          status_of[it.wake_tid] = ST_READY;
          push_ready(it.wake_tid);
        end
        return r;
      end
      KIND_UNUSED: return r;
      KIND_CREATE: begin
        if (thread_total >= MAX_THREADS - 1) begin
          r.table_full = 1'b1;
          refused_creates++;
        end else begin
          thread_total++;
          t = 6'(thread_total % MAX_THREADS);
          lvl_of[t] = (it.priority_req > LEVELS - 1) ? 2'(LEVELS - 1) : it.priority_req[1:0];
          runtime_of[t] = '0;
          status_of[t] = ST_READY;
          push_ready(t);
          r.created_tid = t;
        end
      end
      default: ;
    endcase

    if (cur_valid) begin
      t = cur_tid;
      lv = lvl_of[t];
      rt = runtime_of[t] + ((lv == 0) ? STEP_L0 : (lv == 1) ? STEP_L1 : STEP_HI);
      if (rt > RT_SAT) rt = RT_SAT;
      if (lv >= 2 && rt >= BOOST_AT) begin
        lv = 0;
        rt = 0;
        boosts++;
      end
      runtime_of[t] = 8'(rt);
      if (disp == DISP_EXIT) begin
        status_of[t] = ST_FREE;
      end else if (disp == DISP_WAIT) begin
        status_of[t] = ST_WAIT;
      end else begin
        if (lv < LEVELS - 1) lv++;
        status_of[t] = ST_READY;
        lvl_of[t] = 2'(lv);
        push_ready(t);
      end
      lvl_of[t] = 2'(lv);
    end

    // dispatch the head of the first non-empty level
    cur_valid = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!r.dispatched && fifo_fill[l] != 0) begin
        t = fifo_mem[l][fifo_head[l]];
        fifo_head[l] = (fifo_head[l] + 1) % MAX_THREADS;
        fifo_fill[l]--;
        cur_tid = t;
        cur_valid = 1'b1;
        r.dispatched = 1'b1;
        r.next_tid = t;
        r.next_level = 2'(l);
        r.quantum_us = quantum_cfg[l];
      end
    end
    if (!r.dispatched) idle_schedules++;
    return r;
  endfunction

  // mostly schedules; wakes aim at parked threads so the queues stay busy
  function automatic sched_item_t random_item();
    sched_item_t  it;
    int unsigned  roll;
    logic [5:0]   sleepers [$];
    it.kind = KIND_SCHED;
    it.priority_req = 4'($urandom_range(0, 15));
    it.wake_tid = 6'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < 3) it.disposition = DISP_EXIT;
    else if (roll < 30) it.disposition = DISP_WAIT;
    else if (roll < 38) it.disposition = DISP_ODD;
    else it.disposition = DISP_READY;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      it.kind = KIND_CREATE;
    end else if (roll < 8) begin
      it.kind = KIND_UNUSED;
    end else if (roll < 30) begin
      it.kind = KIND_WAKE;
      for (int t = 1; t <= thread_total; t++)
        if (status_of[t] == ST_WAIT) sleepers.push_back(6'(t));
      if (sleepers.size() != 0 && $urandom_range(0, 99) < 85)
        it.wake_tid = sleepers[$urandom_range(0, sleepers.size() - 1)];
      else
        it.wake_tid = 6'($urandom_range(1, thread_total));
    end
    return it;
  endfunction

  task automatic send_item(input sched_item_t it, input logic typed, input sched_result_t want);
    sched_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    kind <= it.kind;
    priority_req <= it.priority_req;
    disposition <= it.disposition;
    wake_tid <= it.wake_tid;
    do @(posedge clk); while (req_stall);
    r = predict_decision(it);
    awaited_decisions.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic write_quantum(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    quantum_cfg[idx] = val;
  endtask

  task automatic settle();
    while (awaited_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_decisions.size() == 0) begin
        $display("%0t ns: item with nothing awaited, next_tid %0d", $time, next_tid);
        mismatches++;
      end else begin
        want = awaited_decisions.pop_front();
        check_field("created_tid", want.created_tid, created_tid);
        check_field("table_full", want.table_full, table_full);
        check_field("dispatched", want.dispatched, dispatched);
        check_field("next_tid", want.next_tid, next_tid);
        check_field("next_level", want.next_level, next_level);
        check_field("quantum_us", want.quantum_us, quantum_us);
        results_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d items still awaited", cycle_count,
             awaited_decisions.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [19:0] q0, q1, q2;
    quantum_cfg[0] = 20'd25000;
    quantum_cfg[1] = 20'd50000;
    quantum_cfg[2] = 20'd100000;
    foreach (status_of[i]) begin
      status_of[i] = ST_FREE;
      lvl_of[i] = '0;
      runtime_of[i] = '0;
    end
    status_of[1] = ST_READY;

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    req_idle_pct = 12;
    rsp_stall_pct = 88;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    @(negedge clk) req_valid <= 1'b0;
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      req_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 88 : 0;
      rsp_stall_pct = (seg < 2) ? 88 : (seg < 4) ? 12 : 0;
      case (seg)
        0: begin
          q0 = 20'd0; q1 = 20'd0; q2 = 20'd0;
        end
        1: begin
          q0 = 20'd999999; q1 = 20'd999999; q2 = 20'd999999;
        end
        2: begin
          q0 = 20'd1; q1 = 20'd524288; q2 = 20'd999999;
        end
        default: begin
          q0 = 20'($urandom_range(0, 999999));
          q1 = 20'($urandom_range(0, 999999));
          q2 = 20'($urandom_range(0, 999999));
        end
      endcase
      write_quantum(CFG_QUANTUM0, q0);
      write_quantum(CFG_QUANTUM1, q1);
      write_quantum(CFG_QUANTUM2, q2);
      @(negedge clk) cfg_valid <= 1'b0;

      repeat (SEG_ITEMS) send_item(random_item(), 1'b0, '0);
      @(negedge clk) req_valid <= 1'b0;
      settle();
    end

    $display("%0d items sent, %0d results checked over %0d quantum settings", items_sent,
             results_checked, SEGMENTS + 1);
    $display("%0d creates refused on a full table, %0d schedules with no thread, %0d boosts",
             refused_creates, idle_schedules, boosts);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[multilevel_feedback_thread_scheduler.f]
rtl/mlfts_pkg.sv
rtl/multilevel_feedback_thread_scheduler.sv
test/tb_multilevel_feedback_thread_scheduler.sv
